// ===== rtl/core/pia_pkg.sv =====
// package for the primitive index assembler: topology and request codes,
// defaults for the index width and the depth of the result queue
// no dependencies
`timescale 1ns / 1ps

package pia_pkg;

  // default vertex index width
  localparam int INDEX_WIDTH_DEF = 16;

  // primitive total width
  localparam int TOTAL_WIDTH = 32;

  // result queue depth, room for a quad pair while one result waits
  localparam int QUEUE_DEPTH_DEF = 3;

  // maximum results caused by one vertex
  localparam int MAX_RESULTS = 2;

  // request codes
  typedef enum logic {
    REQ_VERTEX  = 1'b0,
    REQ_RESTART = 1'b1
  } req_e;

  // topology codes, the unused code falls to the points behavior
  typedef enum logic [2:0] {
    TOPO_TRI_LIST   = 3'd0,
    TOPO_TRI_STRIP  = 3'd1,
    TOPO_TRI_FAN    = 3'd2,
    TOPO_QUADS      = 3'd3,
    TOPO_LINE_LIST  = 3'd4,
    TOPO_LINE_STRIP = 3'd5,
    TOPO_POINTS     = 3'd6
  } topo_e;

  // push request from the assembler into the result queue
  typedef struct packed {
    logic [1:0] push_cnt;
  } queue_ctl_t;

  // queue status back to the assembler
  typedef struct packed {
    logic room;
  } queue_stat_t;

endpackage

// ===== rtl/core/pia_vtx_if.sv =====
// vertex event channel: valid/ready handshake with request, topology and
// batch start payload; no dependencies
`timescale 1ns / 1ps

interface pia_vtx_if;

  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] topology;
  logic       batch_start;

  modport source (
    output valid,
    output req_type,
    output topology,
    output batch_start,
    input  ready
  );

  modport sink (
    input  valid,
    input  req_type,
    input  topology,
    input  batch_start,
    output ready
  );

endinterface

// ===== rtl/core/pia_prim_if.sv =====
// primitive result channel: valid/ready handshake with three indices, line
// flag, last flag and running total; depends on pia_pkg for defaults
`timescale 1ns / 1ps

interface pia_prim_if #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF
);

  logic                             valid;
  logic                             ready;
  logic [INDEX_WIDTH-1:0]           idx_first;
  logic [INDEX_WIDTH-1:0]           idx_second;
  logic [INDEX_WIDTH-1:0]           idx_third;
  logic                             is_line;
  logic                             last;
  logic [pia_pkg::TOTAL_WIDTH-1:0]  prim_total;

  modport source (
    output valid,
    output idx_first,
    output idx_second,
    output idx_third,
    output is_line,
    output last,
    output prim_total,
    input  ready
  );

  modport sink (
    input  valid,
    input  idx_first,
    input  idx_second,
    input  idx_third,
    input  is_line,
    input  last,
    input  prim_total,
    output ready
  );

endinterface

// ===== rtl/core/pia_prim_queue.sv =====
// shifting result queue: takes up to two entries per cycle, gives one
// entry per cycle from its head register while the output is ready; depends on pia_pkg
`timescale 1ns / 1ps

module pia_prim_queue #(
  parameter int WIDTH = 82,
  parameter int DEPTH = pia_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pia_pkg::queue_ctl_t  ctl_i,
  input  logic [WIDTH-1:0]     push_data0_i,
  input  logic [WIDTH-1:0]     push_data1_i,
  output pia_pkg::queue_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WIDTH-1:0]     out_data_o
);
  import pia_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [WIDTH-1:0] slot_d [DEPTH];
  logic [CW-1:0]    occ_q, occ_d;
  logic [CW-1:0]    occ_keep;
  logic             pop;

  // head of queue drives the output
  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = slot_q[0];
  assign pop         = out_valid_o & out_ready_i;

  // room for a full pair regardless of the output side
  assign stat_o.room = (occ_q <= CW'(DEPTH - MAX_RESULTS));

  // shift on pop, append new entries behind the kept ones
  always_comb begin
    occ_keep = occ_q - CW'(pop);
    occ_d    = occ_keep + CW'(ctl_i.push_cnt);
    for (int i = 0; i < DEPTH; i++) begin
      slot_d[i] = slot_q[i];
      if (i < int'(occ_keep)) begin
        if (pop && (i < DEPTH - 1)) begin
          slot_d[i] = slot_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if ((i == int'(occ_keep)) && (ctl_i.push_cnt != 2'd0)) begin
        slot_d[i] = push_data0_i;
      end else if ((i == int'(occ_keep) + 1) && (ctl_i.push_cnt == 2'd2)) begin
        slot_d[i] = push_data1_i;
      end
    end
  end

  // occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_pair_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.push_cnt == 2'd2) |-> (occ_q <= CW'(DEPTH - MAX_RESULTS)))
    else $error("pair pushed without room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (occ_q == CW'(1)) && (ctl_i.push_cnt == 2'd0)) |=> (occ_q == '0))
    else $error("queue did not drain");

  a_pop_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (occ_q > CW'(1))) |=> (slot_q[0] == $past(slot_q[1])))
    else $error("queue head not advanced on pop");
`endif

endmodule

// ===== rtl/core/primitive_index_assembler.sv =====
// primitive index assembler: a result is written into the result queue when
// its vertex transaction is accepted and shows at the output from the queue's
// head register; one vertex is accepted every cycle while the result queue holds
// at most one entry, so a quad-completing vertex (two results) can hold the input back until the queue drains.
// reset (async, active low) clears counters, batch state and the queue.
// depends on pia_pkg, pia_vtx_if, pia_prim_if and pia_prim_queue
`timescale 1ns / 1ps

module primitive_index_assembler #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pia_vtx_if.sink   vtx_i,
  pia_prim_if.source prim_o
);
  import pia_pkg::*;

  localparam int IW      = INDEX_WIDTH;
  localparam int TW      = TOTAL_WIDTH;
  localparam int ENTRY_W = 3 * IW + 2 + TW;

  // architectural state
  logic [IW-1:0] nvi_q, nvi_d;
  logic [IW-1:0] base_q, base_d;
  logic [2:0]    kind_q, kind_d;
  logic [1:0]    phase_q, phase_d;
  logic [1:0]    seen_q, seen_d;
  logic          wind_q, wind_d;
  logic [TW-1:0] total_q, total_d;

  // effective batch state after a possible batch start
  logic [IW-1:0] base_eff;
  logic [2:0]    kind_eff;
  logic [1:0]    phase_eff;
  logic [1:0]    seen_eff;
  logic          wind_eff;

  logic          accept;
  logic          is_vertex;
  logic [IW-1:0] v, v_m1, v_m2, v_m3;

  // primitive fields for the two result slots
  logic [IW-1:0] p0_a, p0_b, p0_c, p1_a, p1_b, p1_c;
  logic          p_line, p0_last;
  logic [1:0]    n_res;

  queue_ctl_t       q_ctl;
  queue_stat_t      q_stat;
  logic [ENTRY_W-1:0] push0, push1, head;

  assign accept    = vtx_i.valid & vtx_i.ready;
  assign is_vertex = (vtx_i.req_type == REQ_VERTEX);
  assign vtx_i.ready = q_stat.room;

  assign v    = nvi_q;
  assign v_m1 = nvi_q - IW'(1);
  assign v_m2 = nvi_q - IW'(2);
  assign v_m3 = nvi_q - IW'(3);

  // batch start override
  always_comb begin
    if (vtx_i.batch_start) begin
      kind_eff  = vtx_i.topology;
      base_eff  = nvi_q;
      phase_eff = 2'd0;
      seen_eff  = 2'd0;
      wind_eff  = 1'b0;
    end else begin
      kind_eff  = kind_q;
      base_eff  = base_q;
      phase_eff = phase_q;
      seen_eff  = seen_q;
      wind_eff  = wind_q;
    end
  end

  // per-topology primitive assembly and next batch state
  always_comb begin
    n_res   = 2'd0;
    p0_a    = v_m2;
    p0_b    = v_m1;
    p0_c    = v;
    p1_a    = v_m2;
    p1_b    = v_m1;
    p1_c    = v;
    p_line  = 1'b0;
    p0_last = 1'b1;
    phase_d = phase_eff;
    wind_d  = wind_eff;
    case (kind_eff)
      TOPO_TRI_LIST: begin
        if (phase_eff >= 2'd2) begin
          n_res   = 2'd1;
          phase_d = 2'd0;
        end else begin
          phase_d = phase_eff + 2'd1;
        end
      end
      TOPO_TRI_STRIP: begin
        if (seen_eff >= 2'd2) begin
          n_res = 2'd1;
          if (wind_eff) begin
            p0_b = v;
            p0_c = v_m1;
          end
          wind_d = ~wind_eff;
        end
      end
      TOPO_TRI_FAN: begin
        if (seen_eff >= 2'd2) begin
          n_res = 2'd1;
          p0_a  = base_eff;
        end
      end
      TOPO_QUADS: begin
        if (phase_eff >= 2'd3) begin
          n_res   = 2'd2;
          p0_a    = v_m3;
          p0_b    = v_m2;
          p0_last = 1'b0;
          phase_d = 2'd0;
        end else begin
          phase_d = phase_eff + 2'd1;
        end
      end
      TOPO_LINE_LIST: begin
        p_line = 1'b1;
        p0_a   = v_m1;
        p0_b   = v;
        p0_c   = '0;
        if (phase_eff >= 2'd1) begin
          n_res   = 2'd1;
          phase_d = 2'd0;
        end else begin
          phase_d = phase_eff + 2'd1;
        end
      end
      TOPO_LINE_STRIP: begin
        p_line = 1'b1;
        p0_a   = v_m1;
        p0_b   = v;
        p0_c   = '0;
        if (seen_eff >= 2'd1) begin
          n_res = 2'd1;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  // result entries and push control
  assign push0 = {p0_a, p0_b, p0_c, p_line, p0_last, total_q + TW'(1)};
  assign push1 = {p1_a, p1_b, p1_c, 1'b0, 1'b1, total_q + TW'(2)};
  assign q_ctl.push_cnt = (accept && is_vertex) ? n_res : 2'd0;

  // next state for restart and vertex transactions
  always_comb begin
    nvi_d   = nvi_q;
    base_d  = base_q;
    kind_d  = kind_q;
    seen_d  = seen_q;
    total_d = total_q;
    if (accept) begin
      if (!is_vertex) begin
        nvi_d   = '0;
        base_d  = '0;
        seen_d  = 2'd0;
        total_d = '0;
      end else begin
        nvi_d   = nvi_q + IW'(1);
        base_d  = base_eff;
        kind_d  = kind_eff;
        seen_d  = (seen_eff < 2'd2) ? seen_eff + 2'd1 : seen_eff;
        total_d = total_q + TW'(n_res);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvi_q   <= '0;
      base_q  <= '0;
      kind_q  <= TOPO_TRI_LIST;
      phase_q <= 2'd0;
      seen_q  <= 2'd0;
      wind_q  <= 1'b0;
      total_q <= '0;
    end else begin
      nvi_q   <= nvi_d;
      base_q  <= base_d;
      kind_q  <= kind_d;
      seen_q  <= seen_d;
      total_q <= total_d;
      if (accept) begin
        phase_q <= is_vertex ? phase_d : 2'd0;
        wind_q  <= is_vertex ? wind_d : 1'b0;
      end
    end
  end

  // result queue
  pia_prim_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (q_ctl),
    .push_data0_i (push0),
    .push_data1_i (push1),
    .stat_o       (q_stat),
    .out_valid_o  (prim_o.valid),
    .out_ready_i  (prim_o.ready),
    .out_data_o   (head)
  );

  // unpack head entry onto the output channel
  assign prim_o.idx_first  = head[ENTRY_W-1 -: IW];
  assign prim_o.idx_second = head[ENTRY_W-1-IW -: IW];
  assign prim_o.idx_third  = head[ENTRY_W-1-2*IW -: IW];
  assign prim_o.is_line    = head[TW+1];
  assign prim_o.last       = head[TW];
  assign prim_o.prim_total = head[TW-1:0];

`ifndef NO_ASSERTIONS
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_vertex) |=> ((nvi_q == '0) && (total_q == '0) && (base_q == '0)))
    else $error("restart did not clear counters");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_vertex) |=> (nvi_q == $past(nvi_q) + IW'(1)))
    else $error("vertex index did not advance");

  a_no_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vtx_i.ready |-> (q_ctl.push_cnt == 2'd0))
    else $error("push while input stalled");

  a_total_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_vertex) |=> (total_q == $past(total_q) + TW'($past(n_res))))
    else $error("primitive total out of step");
`endif

endmodule

// ===== bench/tb_primitive_index_assembler.sv =====
`timescale 1ns / 1ps
// testbench for primitive_index_assembler: directed topology and restart tests plus
// a long random batch stream, all checked by a scoreboard of predicted primitives
// depends on pia_pkg, pia_vtx_if, pia_prim_if and the assembler rtl

module tb_primitive_index_assembler;

  import pia_pkg::*;

  localparam int IDX_W       = 16;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 1950;

  // topology code with no primitive behavior of its own
  localparam logic [2:0] TOPO_UNUSED = 3'd7;

  // one expected or observed primitive
  typedef struct packed {
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [IDX_W-1:0] c_idx;
    logic             line_flag;
    logic             last_flag;
    logic [31:0]      total;
  } prim_t;

  logic clk;
  logic rst_n;

  pia_vtx_if                       vtx ();
  pia_prim_if #(.INDEX_WIDTH(IDX_W)) prim ();

  primitive_index_assembler #(
    .INDEX_WIDTH(IDX_W)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .vtx_i (vtx),
    .prim_o(prim)
  );

  // predictor state, matches the block right after reset
  logic [IDX_W-1:0] nxt_idx  = '0;
  logic [IDX_W-1:0] base_idx = '0;
  logic [2:0]       kind     = TOPO_TRI_LIST;
  logic [1:0]       phase    = '0;
  logic [1:0]       seen     = '0;
  logic             odd      = 1'b0;
  logic [31:0]      total    = '0;

  prim_t prims_due[$];

  int  errors        = 0;
  int  n_vertices    = 0;
  int  n_restarts    = 0;
  int  n_checked     = 0;
  int  cycles        = 0;
  bit  src_gaps_on   = 1'b0;
  bit  sink_stalls_on = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d primitives still due", $time, cycles,
               prims_due.size());
      $display("tb_primitive_index_assembler: errors");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // queue one expected primitive and advance the running total
  function automatic void emit_prim(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                    logic [IDX_W-1:0] c, logic line, logic fin);
    prim_t p;
    total       = total + 32'd1;
    p.a_idx     = a;
    p.b_idx     = b;
    p.c_idx     = line ? '0 : c;
    p.line_flag = line;
    p.last_flag = fin;
    p.total     = total;
    prims_due.push_back(p);
  endfunction

  // primitive assembly for one accepted vertex transaction
  function automatic void assemble_vertex(logic req, logic [2:0] topo, logic bstart);
    logic [IDX_W-1:0] v;
    if (req == REQ_RESTART) begin
      nxt_idx  = '0;
      base_idx = '0;
      phase    = '0;
      seen     = '0;
      odd      = 1'b0;
      total    = '0;
      return;
    end
    if (bstart) begin
      kind     = topo;
      base_idx = nxt_idx;
      phase    = '0;
      seen     = '0;
      odd      = 1'b0;
    end
    v = nxt_idx;
    case (kind)
      TOPO_TRI_LIST: begin
        if (phase >= 2) begin
          emit_prim(v - IDX_W'(2), v - IDX_W'(1), v, 1'b0, 1'b1);
          phase = '0;
        end else begin
          phase = phase + 2'd1;
        end
      end
      TOPO_TRI_STRIP: begin
        if (seen >= 2) begin
          if (odd) emit_prim(v - IDX_W'(2), v, v - IDX_W'(1), 1'b0, 1'b1);
          else     emit_prim(v - IDX_W'(2), v - IDX_W'(1), v, 1'b0, 1'b1);
          odd = ~odd;
        end
      end
      TOPO_TRI_FAN: begin
        if (seen >= 2) emit_prim(base_idx, v - IDX_W'(1), v, 1'b0, 1'b1);
      end
      TOPO_QUADS: begin
        if (phase >= 3) begin
          emit_prim(v - IDX_W'(3), v - IDX_W'(2), v, 1'b0, 1'b0);
          emit_prim(v - IDX_W'(2), v - IDX_W'(1), v, 1'b0, 1'b1);
          phase = '0;
        end else begin
          phase = phase + 2'd1;
        end
      end
      TOPO_LINE_LIST: begin
        if (phase >= 1) begin
          emit_prim(v - IDX_W'(1), v, '0, 1'b1, 1'b1);
          phase = '0;
        end else begin
          phase = phase + 2'd1;
        end
      end
      TOPO_LINE_STRIP: begin
        if (seen >= 1) emit_prim(v - IDX_W'(1), v, '0, 1'b1, 1'b1);
      end
      default: begin
        // points and the unused code only take an index
      end
    endcase
    if (seen < 2) seen = seen + 2'd1;
    nxt_idx = v + IDX_W'(1);
  endfunction

  // send one vertex transaction, predict on acceptance, then maybe idle
  task automatic send_vertex(logic req, logic [2:0] topo, logic bstart);
    int gap;
    vtx.valid       <= 1'b1;
    vtx.req_type    <= req;
    vtx.topology    <= topo;
    vtx.batch_start <= bstart;
    do @(posedge clk); while (!vtx.ready);
    assemble_vertex(req, topo, bstart);
    if (req == REQ_RESTART) n_restarts++;
    else n_vertices++;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 99) < 30) gap = pick_idle_len();
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the source until every predicted primitive has arrived
  task automatic settle_results();
    vtx.valid <= 1'b0;
    do @(posedge clk); while (prims_due.size() != 0);
  endtask

  // one batch: topology latched on the first vertex, random tags on the rest
  task automatic send_batch(logic [2:0] topo, int len);
    send_vertex(REQ_VERTEX, topo, 1'b1);
    for (int i = 1; i < len; i++) send_vertex(REQ_VERTEX, 3'($urandom_range(0, 7)), 1'b0);
  endtask

  // sink side: random stall stretches
  initial begin
    int stall_left;
    stall_left = 0;
    prim.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        prim.ready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_idle_len() - 1;
        prim.ready <= 1'b0;
      end else begin
        prim.ready <= 1'b1;
      end
    end
  end

  task automatic report_field(string fld, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, fld, exp_v, got_v);
  endtask

  // compare each output transaction against the oldest prediction
  always @(posedge clk) begin
    prim_t got;
    prim_t want;
    bit    bad;
    if (rst_n && prim.valid && prim.ready) begin
      got = '{prim.idx_first, prim.idx_second, prim.idx_third, prim.is_line, prim.last,
              prim.prim_total};
      if (prims_due.size() == 0) begin
        $display("%0t unexpected primitive: expected none, got %p", $time, got);
        errors++;
      end else begin
        want = prims_due.pop_front();
        bad  = 1'b0;
        if (got.a_idx !== want.a_idx) begin
          report_field("idx_first", 32'(want.a_idx), 32'(got.a_idx));
          bad = 1'b1;
        end
        if (got.b_idx !== want.b_idx) begin
          report_field("idx_second", 32'(want.b_idx), 32'(got.b_idx));
          bad = 1'b1;
        end
        if (got.c_idx !== want.c_idx) begin
          report_field("idx_third", 32'(want.c_idx), 32'(got.c_idx));
          bad = 1'b1;
        end
        if (got.line_flag !== want.line_flag) begin
          report_field("is_line", 32'(want.line_flag), 32'(got.line_flag));
          bad = 1'b1;
        end
        if (got.last_flag !== want.last_flag) begin
          report_field("last", 32'(want.last_flag), 32'(got.last_flag));
          bad = 1'b1;
        end
        if (got.total !== want.total) begin
          report_field("prim_total", want.total, got.total);
          bad = 1'b1;
        end
        if (bad) errors++;
        n_checked++;
      end
    end
  end

  // first vertices after reset continue the default triangle list at base 0
  task automatic test_default_batch();
    for (int i = 0; i < 3; i++) send_vertex(REQ_VERTEX, TOPO_TRI_LIST, 1'b0);
  endtask

  // every topology but the triangle list once, including the unused code and incomplete tails
  task automatic test_each_topology();
    send_batch(TOPO_TRI_STRIP, 4);
    send_batch(TOPO_TRI_FAN, 4);
    send_batch(TOPO_QUADS, 4);
    send_batch(TOPO_LINE_LIST, 3);
    send_batch(TOPO_LINE_STRIP, 3);
    send_vertex(REQ_VERTEX, TOPO_POINTS, 1'b1);
    send_vertex(REQ_VERTEX, TOPO_UNUSED, 1'b1);
  endtask

  // restart with all tag bits set, then vertices without batch start keep the old topology and count from index 0
  task automatic test_restart_clears();
    send_vertex(REQ_RESTART, TOPO_UNUSED, 1'b1);
    send_vertex(REQ_VERTEX, TOPO_TRI_LIST, 1'b0);
    send_vertex(REQ_VERTEX, TOPO_TRI_LIST, 1'b0);
    send_vertex(REQ_VERTEX, TOPO_TRI_LIST, 1'b0);
  endtask

  // mostly well-formed batches with random lengths, some restarts and stray vertices
  task automatic random_chunk(int n_items);
    int start;
    int r;
    start = n_vertices + n_restarts;
    while (n_vertices + n_restarts - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_vertex(REQ_RESTART, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else if (r < 10) begin
        send_vertex(REQ_VERTEX, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 9) < 9) begin
        send_batch(3'($urandom_range(0, 7)), $urandom_range(1, 12));
      end else begin
        send_batch(3'($urandom_range(0, 7)), $urandom_range(13, 40));
      end
    end
  endtask

  // random stream in phases with different idling on each side
  task automatic test_random_stream();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    random_chunk(RANDOM_ITEMS / 4);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    random_chunk(RANDOM_ITEMS / 4);
    settle_results();
    sink_stalls_on = 1'b1;
    random_chunk(RANDOM_ITEMS / 4);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b0;
    random_chunk(RANDOM_ITEMS / 8);
    sink_stalls_on = 1'b1;
    random_chunk(RANDOM_ITEMS / 8);
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    rst_n            = 1'b0;
    vtx.valid       <= 1'b0;
    vtx.req_type    <= REQ_VERTEX;
    vtx.topology    <= TOPO_TRI_LIST;
    vtx.batch_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    test_default_batch();
    test_each_topology();
    test_restart_clears();
    test_random_stream();
    settle_results();
    repeat (10) @(posedge clk);
    $display("run: %0d vertices and %0d restarts sent, %0d primitives checked", n_vertices,
             n_restarts, n_checked);
    $display("all seven topology codes plus the unused one, restarts, idle and stall phases");
    if (errors == 0) begin
      $display("tb_primitive_index_assembler: clean");
    end else begin
      $display("%0d failing primitives", errors);
      $display("tb_primitive_index_assembler: errors");
    end
    $finish;
  end

endmodule
